// ----- rtl/periodic_task_tick_scheduler_unit_assert.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ptts_pkg.sv -----
// Package with codes and field widths of the periodic task tick scheduler.
`timescale 1ns / 1ps
package ptts_pkg;

   localparam int PERIOD_W = 32;
   localparam int PRIO_W   = 2;
   localparam int INDEX_W  = 3;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   // request opcodes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   // result kinds
   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_DUE = 1'b1;

   // add status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic [PRIO_W-1:0] HIGHEST_PRIO = 2'd0;
   localparam logic [PRIO_W-1:0] LOWEST_PRIO  = 2'd2;

endpackage

// ----- rtl/periodic_task_tick_scheduler_unit.sv -----
// Top level of the periodic task tick scheduler.
`timescale 1ns / 1ps
// Keeps up to TASK_SLOTS periodic tasks (period, running counter, priority 0..2).
// An add request (tuser = 1) stores a task in the next free slot and returns one
// acknowledgement, or a "table full" status. A tick request (tuser = 0) walks
// priority 0, 1, 2 and, in each level, the stored slots in order: each matching
// task's counter is bumped and, once it reaches its period, cleared and the slot
// reported as due, the final report of the tick marked by tlast. One shared
// increment/compare unit visits each slot once per level through counter and task
// RAMs that each have one write port and one read port with a registered read.
// A tick with no task due returns nothing. Requests are taken only between items.
// No clearing pass is needed after reset: every slot is written when its task is
// added, before any tick reads it.
module periodic_task_tick_scheduler_unit #(
   parameter int TASK_SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] task_period, [33:32] task_priority, [39:34] zero
   input  logic [ptts_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] add_status, [3:1] task_index, [7:4] zero
   output logic [ptts_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] kind
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   import ptts_pkg::*;

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);
   localparam int CFG_W = PERIOD_W + PRIO_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [PRIO_W-1:0]    level_ff, level_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 cfg_we;
   logic [CFG_W-1:0]     cfg_rdata;
   logic                 cnt_we;
   logic [IDX_W-1:0]     cnt_waddr;
   logic [PERIOD_W-1:0]  cnt_wdata;
   logic [PERIOD_W-1:0]  cnt_rdata;

   logic                 out_free;
   logic                 table_full;
   logic [IDX_W-1:0]     add_idx;
   logic [PERIOD_W-1:0]  count_sum;
   logic                 level_match;
   logic                 task_due;
   logic                 last_slot;

   ptts_ram #(
      .WIDTH (CFG_W),
      .DEPTH (TASK_SLOTS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (cfg_we),
      .wr_addr (add_idx),
      .wr_data ({prio_ff, period_ff}),
      .rd_addr (idx_ff),
      .rd_data (cfg_rdata)
   );

   ptts_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (TASK_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (idx_ff),
      .rd_data (cnt_rdata)
   );

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign table_full  = (total_ff == CNT_W'(TASK_SLOTS));
   assign add_idx     = total_ff[IDX_W-1:0];
   // shared unit: one increment and one compare against the period
   assign count_sum   = cnt_rdata + PERIOD_W'(1);
   assign level_match = (cfg_rdata[CFG_W-1:PERIOD_W] == level_ff);
   assign task_due    = level_match && (count_sum >= cfg_rdata[PERIOD_W-1:0]);
   assign last_slot   = (CNT_W'(idx_ff) + CNT_W'(1) == total_ff);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      level_in      = level_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      period_in     = period_ff;
      prio_in       = prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      cfg_we        = 1'b0;
      cnt_we        = 1'b0;
      cnt_waddr     = idx_ff;
      cnt_wdata     = count_sum;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               period_in = req_tdata[PERIOD_W-1:0];
               prio_in   = (req_tdata[PERIOD_W+PRIO_W-1:PERIOD_W] > LOWEST_PRIO) ?
                           LOWEST_PRIO : req_tdata[PERIOD_W+PRIO_W-1:PERIOD_W];
               if (req_tuser == OP_ADD) begin
                  state_in = ST_ADD;
               end else begin
                  idx_in        = '0;
                  level_in      = HIGHEST_PRIO;
                  pend_valid_in = 1'b0;
                  state_in      = (total_ff == '0) ? ST_FLUSH : ST_READ;
               end
            end
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_last_in  = 1'b1;
               if (table_full) begin
                  rsp_status_in = STATUS_FULL;
                  rsp_index_in  = '0;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_index_in  = INDEX_W'(add_idx);
                  cfg_we        = 1'b1;
                  cnt_we        = 1'b1;
                  cnt_waddr     = add_idx;
                  cnt_wdata     = '0;
                  total_in      = total_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // hold the slot while an earlier due report cannot leave
            if (!(task_due && pend_valid_ff && !out_free)) begin
               if (level_match) begin
                  cnt_we = 1'b1;
               end
               if (task_due) begin
                  cnt_wdata = '0;
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_DUE;
                     rsp_status_in = STATUS_OK;
                     rsp_index_in  = INDEX_W'(pend_idx_ff);
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx_ff;
               end
               if (last_slot) begin
                  idx_in = '0;
                  if (level_ff == LOWEST_PRIO) begin
                     state_in = ST_FLUSH;
                  end else begin
                     level_in = level_ff + PRIO_W'(1);
                     state_in = ST_READ;
                  end
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_DUE;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = INDEX_W'(pend_idx_ff);
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      level_ff      <= level_in;
      pend_idx_ff   <= pend_idx_in;
      period_ff     <= period_in;
      prio_ff       <= prio_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - INDEX_W - 1){1'b0}}, rsp_index_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "periodic_task_tick_scheduler_unit_assert.svh"

   `PTTS_ASSERT_NOW(a_idle_no_pending, clock, reset, req_tready, !pend_valid_ff, "due report left pending between requests")
   `PTTS_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == ST_READ, CNT_W'(idx_ff) < total_ff, "scan slot beyond stored tasks")
   `PTTS_ASSERT_NOW(a_level_in_range, clock, reset, state_ff == ST_READ, level_ff <= LOWEST_PRIO, "scan level beyond lowest priority")
   `PTTS_ASSERT_NOW(a_add_not_full, clock, reset, cfg_we, !table_full, "task stored into a full table")
   `PTTS_ASSERT_NEXT(a_due_kept, clock, reset, state_ff == ST_EVAL && task_due && !(pend_valid_ff && !out_free), pend_valid_ff, "due slot not held for report")

endmodule

// ----- rtl/ptts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ptts_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb_periodic_task_tick_scheduler_unit.sv -----
// Self-checking testbench of the periodic task tick scheduler: add and tick streams.
`timescale 1ns / 1ps
module tb_periodic_task_tick_scheduler_unit;
   import ptts_pkg::*;

   localparam int TASK_SLOTS   = 8;
   localparam int RANDOM_ITEMS = 440;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic                 kind;
      logic                 add_status;
      logic [INDEX_W-1:0]   task_index;
      logic                 last;
   } sched_result_type;

   class sched_scoreboard;
      logic [PERIOD_W-1:0] period_tab [TASK_SLOTS];
      logic [PERIOD_W-1:0] count_tab [TASK_SLOTS];
      logic [PRIO_W-1:0]   prio_tab [TASK_SLOTS];
      int                  stored;
      sched_result_type    due_q[$];
      int                  mismatches;

      function new();
         for (int i = 0; i < TASK_SLOTS; i++) begin
            period_tab[i] = '0;
            count_tab[i]  = '0;
            prio_tab[i]   = LOWEST_PRIO;
         end
         stored     = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic op, logic [PERIOD_W-1:0] period,
                                 logic [PRIO_W-1:0] prio);
         sched_result_type r;
         int               fired;
         fired = 0;
         if (op == OP_ADD) begin
            if (stored >= TASK_SLOTS) begin
               r = '{KIND_ACK, STATUS_FULL, '0, 1'b1};
            end else begin
               period_tab[stored] = period;
               count_tab[stored]  = '0;
               prio_tab[stored]   = (prio > LOWEST_PRIO) ? LOWEST_PRIO : prio;
               r = '{KIND_ACK, STATUS_OK, stored[INDEX_W-1:0], 1'b1};
               stored++;
            end
            due_q.push_back(r);
         end else begin
            for (int lvl = HIGHEST_PRIO; lvl <= LOWEST_PRIO; lvl++) begin
               for (int i = 0; i < stored; i++) begin
                  if (prio_tab[i] == lvl) begin
                     count_tab[i] = count_tab[i] + 1;
                     if (count_tab[i] >= period_tab[i]) begin
                        count_tab[i] = '0;
                        r = '{KIND_DUE, STATUS_OK, i[INDEX_W-1:0], 1'b0};
                        due_q.push_back(r);
                        fired++;
                     end
                  end
               end
            end
            // mark the final due report of this tick
            if (fired > 0) begin
               r = due_q.pop_back();
               r.last = 1'b1;
               due_q.push_back(r);
            end
         end
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type exp;
         if (due_q.size() == 0) begin
            $error("unexpected result: kind %0d status %0d index %0d last %0d",
                   got.kind, got.add_status, got.task_index, got.last);
            mismatches++;
            return;
         end
         exp = due_q.pop_front();
         if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, actual %0d", exp.kind, got.kind);
            mismatches++;
         end
         if (got.add_status !== exp.add_status) begin
            $error("add_status: expected %0d, actual %0d", exp.add_status, got.add_status);
            mismatches++;
         end
         if (got.task_index !== exp.task_index) begin
            $error("task_index: expected %0d, actual %0d", exp.task_index, got.task_index);
            mismatches++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, actual %0d", exp.last, got.last);
            mismatches++;
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   sched_scoreboard sched_sb;
   int              idle_cycles;
   int              burst_left;
   int              stall_mode;
   int              stall_phase;

   periodic_task_tick_scheduler_unit #(.TASK_SLOTS(TASK_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Note requests and check results on transfers; track cycles with no transfer.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            sched_sb.note_request(req_tuser, req_tdata[PERIOD_W-1:0],
                                  req_tdata[PERIOD_W+PRIO_W-1:PERIOD_W]);
         if (rsp_tvalid && rsp_tready)
            sched_sb.check_result('{rsp_tuser, rsp_tdata[0], rsp_tdata[INDEX_W:1],
                                    rsp_tlast});
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver stall pattern: always ready, randomly ready, or a repeating ready pattern, in a randomly chosen mode.
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0)
         stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         default: rsp_tready <= (stall_phase % 5 >= 2);
      endcase
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_item(logic op, logic [PERIOD_W-1:0] period, logic [PRIO_W-1:0] prio);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-PERIOD_W-PRIO_W){1'b0}}, prio, period};
      do @(posedge clock); while (!req_tready);
      // close the burst with a random gap
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic send_tick();
      send_item(OP_TICK, $urandom, $urandom_range(0, 3));
   endtask

   initial begin
      sched_sb    = new();
      idle_cycles = 0;
      burst_left  = 0;
      stall_mode  = 0;
      stall_phase = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_TICK;
      rsp_tready  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tick on an empty table, then a tick where nothing is due yet
      send_tick();
      send_item(OP_ADD, 32'd3, 2'd0);
      send_tick();
      send_item(OP_ADD, 32'd0, 2'd3);
      send_item(OP_ADD, 32'd1, 2'd1);
      send_item(OP_ADD, 32'hFFFF_FFFF, 2'd2);
      send_tick();
      send_item(OP_ADD, 32'd2, 2'd0);
      send_item(OP_ADD, 32'd5, 2'd1);
      send_item(OP_ADD, 32'd7, 2'd3);
      send_item(OP_ADD, 32'd4, 2'd0);
      // table is full now
      send_item(OP_ADD, 32'hFFFF_FFFF, 2'd3);
      send_item(OP_ADD, 32'd0, 2'd0);
      repeat (7) send_tick();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            // hold off until every outstanding result has drained
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (sched_sb.pending() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 85)
            send_tick();
         else
            send_item(OP_ADD, $urandom, $urandom_range(0, 3));
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sched_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sched_sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- periodic_task_tick_scheduler_unit.f -----
+incdir+rtl
rtl/ptts_pkg.sv
rtl/ptts_ram.sv
rtl/periodic_task_tick_scheduler_unit.sv
tb/tb_periodic_task_tick_scheduler_unit.sv
